>>> hw/rtl/rqws_pkg.sv
// Shared types, codes and defaults for the ready queue with wait stack.
package rqws_pkg;

    localparam int READY_DEPTH_DEF = 16;
    localparam int STACK_DEPTH_DEF = 16;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int STEP_W  = 16;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_MOVE   = 2'd2,
        K_WAKE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_READY_FULL = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_STACK_EMPTY = 3'd3,
        ST_STACK_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        R_HOLD   = 2'd0,
        R_INSERT = 2'd1,
        R_DELETE = 2'd2
    } ready_op_t;

    typedef enum logic [1:0] {
        S_HOLD = 2'd0,
        S_PUSH = 2'd1,
        S_POP  = 2'd2
    } stack_op_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_APPLY = 1'b1
    } fsm_t;

    // Broadcast to every cell of the ready list.
    typedef struct packed {
        ready_op_t op;
        entry_t    new_entry;
    } ready_ctrl_t;

    // Broadcast to every cell of the wait stack.
    typedef struct packed {
        stack_op_t op;
    } stack_ctrl_t;

endpackage

>>> hw/rtl/rqws_ready_cell.sv
// One slot of the sorted ready list: holds an entry and shifts with its neighbours.
module rqws_ready_cell import rqws_pkg::*; (
    input  logic        aclk,
    input  ready_ctrl_t ctrl,
    input  logic        valid,
    input  logic        prev_keep,
    input  logic        del_shift,
    input  logic [ID_W-1:0] key,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    output entry_t      entry_q,
    output entry_t      entry_d,
    output logic        keep,
    output logic        match
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   goes_after;

    // The new entry goes after this one on higher priority, or equal priority and a step
    // that is not larger, so equal keys stay in arrival order.
    assign goes_after = (entry_reg.prio > ctrl.new_entry.prio) ||
                        ((entry_reg.prio == ctrl.new_entry.prio) &&
                         (entry_reg.step <= ctrl.new_entry.step));
    assign keep  = valid && goes_after;
    assign match = valid && (entry_reg.id == key);

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            R_INSERT: begin
                if (!keep) begin
                    entry_next = prev_keep ? ctrl.new_entry : left_entry;
                end
            end
            R_DELETE: begin
                if (del_shift) begin
                    entry_next = right_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;
    assign entry_d = entry_next;

endmodule

>>> hw/rtl/rqws_stack_cell.sv
// One slot of the wait stack: a shift cell, the top of the stack sits in the first cell.
module rqws_stack_cell import rqws_pkg::*; (
    input  logic        aclk,
    input  stack_ctrl_t ctrl,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    output entry_t      entry_q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        case (ctrl.op)
            S_PUSH:  entry_next = left_entry;
            S_POP:   entry_next = right_entry;
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

>>> hw/rtl/ready_queue_with_wait_stack.sv
// Top level of the scheduler store: sorted ready list and LIFO wait stack built from cells.
//
// The block takes scheduler requests on the s_ channel and returns one result transaction
// on the m_ channel for every request. A request either inserts a process into the ready
// list, removes one by id, moves one by id onto the wait stack, or wakes the top of the
// wait stack back into the ready list. The ready list is kept sorted by priority, highest
// first, then by step number, lowest first; equal keys keep their arrival order.
// Each result carries a status code, the process now at the head of the ready list and
// the occupancy of both lists after the request has been carried out.
//
// Operation: a request is accepted while the block is idle, and during acceptance every
// cell compares its id with the request; the apply state that follows applies the
// operation to all cells at once and loads the result register. A new request is
// accepted only after the one before it has been applied.
//
// When the receiver stalls, the finished result waits in the output register and the
// block still accepts the next request; that request is held in the apply step until
// the output register frees. After reset both lists are empty and no result is pending;
// no clearing pass is needed because only slots below the counts are ever looked at.
module ready_queue_with_wait_stack import rqws_pkg::*; #(
    parameter int READY_DEPTH = READY_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // proc_id[15:0], priority_req[23:16], step_no[39:24]
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // head_valid[0], head_id[16:1], ready_count[21:17],
                                  // waiting_count[26:22], zero above
    output logic [2:0]  m_tuser   // status[2:0]
);

    localparam int RCW = $clog2(READY_DEPTH + 1);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    // Handshake and sequencing.
    fsm_t state_reg;
    fsm_t state_next;
    logic s_accept;
    logic out_free;
    logic apply_en;

    // The request being worked on.
    kind_t            kind_reg;
    entry_t           item_reg;
    logic [READY_DEPTH-1:0] match_reg;

    // Occupancy.
    logic [RCW-1:0] ready_cnt_reg;
    logic [RCW-1:0] ready_cnt_next;
    logic [SCW-1:0] stack_cnt_reg;
    logic [SCW-1:0] stack_cnt_next;

    // Result register.
    logic           m_tvalid_reg;
    logic           m_tvalid_next;
    status_t        status_reg;
    status_t        status_next;
    logic           head_valid_reg;
    logic [ID_W-1:0] head_id_reg;
    logic [COUNT_W-1:0] ready_out_reg;
    logic [COUNT_W-1:0] stack_out_reg;

    // Cell rows.
    ready_ctrl_t rctrl;
    stack_ctrl_t sctrl;
    entry_t ready_q [READY_DEPTH];
    entry_t ready_d [READY_DEPTH];
    entry_t stack_q [STACK_DEPTH];
    logic [READY_DEPTH-1:0] cell_valid;
    logic [READY_DEPTH-1:0] cell_keep;
    logic [READY_DEPTH-1:0] cell_match;
    logic [READY_DEPTH-1:0] first_oh;
    logic [READY_DEPTH-1:0] del_mask;
    entry_t sel_entry;
    entry_t push_entry;

    logic found;
    logic ready_full;
    logic stack_full;
    logic stack_empty;

    // ------------------------------------------------------------------
    // Sequencing: accept a request, then apply it once the result register is free.
    // ------------------------------------------------------------------
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (s_tvalid) state_next = FSM_APPLY;
            FSM_APPLY: if (out_free) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        apply_en = 1'b0;
        case (state_reg)
            FSM_IDLE:  s_tready = 1'b1;
            FSM_APPLY: apply_en = out_free;
            default: begin
                s_tready = 1'b0;
                apply_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The id comparison runs in every cell during the accept cycle, the list being
    // stable while the block is idle.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg      <= kind_t'(s_tuser);
            item_reg.id   <= s_tdata[15:0];
            item_reg.prio <= s_tdata[23:16];
            item_reg.step <= s_tdata[39:24];
            match_reg     <= cell_match;
        end
    end

    // ------------------------------------------------------------------
    // Ready list cells.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < READY_DEPTH; i++) begin
            cell_valid[i] = ready_cnt_reg > RCW'(i);
        end
    end

    // The first matching slot and every slot from it upwards, which close the gap on delete.
    assign first_oh = match_reg & (~match_reg + 1'b1);
    assign del_mask = ~(first_oh - 1'b1);
    assign found    = |match_reg;

    always_comb begin
        sel_entry = '0;
        for (int i = 0; i < READY_DEPTH; i++) begin
            sel_entry = sel_entry | (ready_q[i] & {$bits(entry_t){first_oh[i]}});
        end
    end

    for (genvar i = 0; i < READY_DEPTH; i++) begin : g_ready
        entry_t left_e;
        entry_t right_e;
        logic   prev_k;
        if (i == 0) begin : g_first
            assign left_e = rctrl.new_entry;
            assign prev_k = 1'b1;
        end else begin : g_rest
            assign left_e = ready_q[i-1];
            assign prev_k = cell_keep[i-1];
        end
        if (i == READY_DEPTH - 1) begin : g_last
            assign right_e = ready_q[i];
        end else begin : g_inner
            assign right_e = ready_q[i+1];
        end
        rqws_ready_cell u_cell (
            .aclk        (aclk),
            .ctrl        (rctrl),
            .valid       (cell_valid[i]),
            .prev_keep   (prev_k),
            .del_shift   (del_mask[i]),
            .key         (s_tdata[15:0]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry_q     (ready_q[i]),
            .entry_d     (ready_d[i]),
            .keep        (cell_keep[i]),
            .match       (cell_match[i])
        );
    end

    // ------------------------------------------------------------------
    // Wait stack cells; the top of the stack is the first cell.
    // ------------------------------------------------------------------
    assign push_entry = sel_entry;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
        entry_t left_e;
        entry_t right_e;
        if (i == 0) begin : g_first
            assign left_e = push_entry;
        end else begin : g_rest
            assign left_e = stack_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign right_e = stack_q[i];
        end else begin : g_inner
            assign right_e = stack_q[i+1];
        end
        rqws_stack_cell u_cell (
            .aclk        (aclk),
            .ctrl        (sctrl),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry_q     (stack_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Operation decode for the apply cycle.
    // ------------------------------------------------------------------
    assign ready_full  = ready_cnt_reg == RCW'(READY_DEPTH);
    assign stack_full  = stack_cnt_reg == SCW'(STACK_DEPTH);
    assign stack_empty = stack_cnt_reg == '0;

    always_comb begin
        rctrl.op        = R_HOLD;
        rctrl.new_entry = item_reg;
        sctrl.op        = S_HOLD;
        status_next     = ST_OK;
        ready_cnt_next  = ready_cnt_reg;
        stack_cnt_next  = stack_cnt_reg;
        if (apply_en) begin
            case (kind_reg)
                K_INSERT: begin
                    if (ready_full) begin
                        status_next = ST_READY_FULL;
                    end else begin
                        rctrl.op       = R_INSERT;
                        ready_cnt_next = ready_cnt_reg + 1'b1;
                    end
                end
                K_REMOVE: begin
                    if (!found) begin
                        status_next = ST_NOT_FOUND;
                    end else begin
                        rctrl.op       = R_DELETE;
                        ready_cnt_next = ready_cnt_reg - 1'b1;
                    end
                end
                K_MOVE: begin
                    // A missing id is reported ahead of a full stack.
                    if (!found) begin
                        status_next = ST_NOT_FOUND;
                    end else if (stack_full) begin
                        status_next = ST_STACK_FULL;
                    end else begin
                        rctrl.op       = R_DELETE;
                        sctrl.op       = S_PUSH;
                        ready_cnt_next = ready_cnt_reg - 1'b1;
                        stack_cnt_next = stack_cnt_reg + 1'b1;
                    end
                end
                K_WAKE: begin
                    // With a full ready list the woken entry stays on the stack.
                    if (stack_empty) begin
                        status_next = ST_STACK_EMPTY;
                    end else if (ready_full) begin
                        status_next = ST_READY_FULL;
                    end else begin
                        rctrl.op        = R_INSERT;
                        rctrl.new_entry = stack_q[0];
                        sctrl.op        = S_POP;
                        ready_cnt_next  = ready_cnt_reg + 1'b1;
                        stack_cnt_next  = stack_cnt_reg - 1'b1;
                    end
                end
                default: status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_cnt_reg <= '0;
            stack_cnt_reg <= '0;
        end else begin
            ready_cnt_reg <= ready_cnt_next;
            stack_cnt_reg <= stack_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: reports the state as it stands after the operation.
    // ------------------------------------------------------------------
    assign m_tvalid_next = apply_en || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_en) begin
            status_reg     <= status_next;
            head_valid_reg <= ready_cnt_next != '0;
            head_id_reg    <= (ready_cnt_next != '0) ? ready_d[0].id : '0;
            ready_out_reg  <= COUNT_W'(ready_cnt_next);
            stack_out_reg  <= COUNT_W'(stack_cnt_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {5'd0, stack_out_reg, ready_out_reg, head_id_reg, head_valid_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_ready_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_cnt_reg <= RCW'(READY_DEPTH))
        else $error("ready list count above its depth");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_cnt_reg <= SCW'(STACK_DEPTH))
        else $error("wait stack count above its depth");

    a_accept_to_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == FSM_APPLY)
        else $error("accepted transaction not followed by the apply step");

    a_count_only_on_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (ready_cnt_reg != $past(ready_cnt_reg))) |->
            ($past(apply_en) && m_tvalid_reg))
        else $error("ready count changed without a result being produced");

endmodule

>>> test/ready_queue_with_wait_stack_tb.sv
// Self-checking testbench for the scheduler store with sorted ready list and wait stack.
`timescale 1ns / 100ps

module ready_queue_with_wait_stack_tb;
    import rqws_pkg::*;

    // The run is cut off here if the results stop coming. The slowest correct run is
    // roughly 1100 requests with sender gaps, receiver stalls and a few long hold-offs,
    // and it ends before this limit is reached.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 960;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // One result transaction as the block should return it.
    typedef struct {
        status_t            status;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [COUNT_W-1:0] ready_count;
        logic [COUNT_W-1:0] waiting_count;
    } sched_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // proc_id[15:0], priority_req[23:16], step_no[39:24]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // head_valid[0], head_id[16:1], ready_count[21:17],
                            // waiting_count[26:22], zero above
    logic [2:0]  m_tuser;   // status[2:0]

    // Mirror of the block's state, advanced as each request is issued.
    entry_t ready_list[READY_DEPTH_DEF];
    entry_t wait_stack[STACK_DEPTH_DEF];
    int     ready_used;
    int     stack_used;

    // Results still owed by the block, oldest first.
    sched_result_t owed_results[$];

    int          fault_count;
    int unsigned cycle_count;
    bit          sender_gaps_on;
    bit          receiver_gaps_on;
    int          rx_hold_cycles;

    ready_queue_with_wait_stack DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung block or a lost result ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ready_queue_with_wait_stack_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Scheduler store predictor
    // ---------------------------------------------------------------------------------

    // Sorted insertion: higher priority first, then lower step, and an entry whose keys
    // equal those already present lands behind them so that ties stay first come first
    // served. Returns 0 when the list is already full.
    function automatic bit ready_push_sorted(entry_t e);
        int pos;
        if (ready_used >= READY_DEPTH_DEF) begin
            return 1'b0;
        end
        pos = 0;
        while (pos < ready_used &&
               (ready_list[pos].prio > e.prio ||
                (ready_list[pos].prio == e.prio && ready_list[pos].step <= e.step))) begin
            pos++;
        end
        for (int k = ready_used; k > pos; k--) begin
            ready_list[k] = ready_list[k-1];
        end
        ready_list[pos] = e;
        ready_used++;
        return 1'b1;
    endfunction

    // Position of the first entry carrying this id, or -1 when there is none.
    function automatic int ready_find(logic [ID_W-1:0] id);
        for (int i = 0; i < ready_used; i++) begin
            if (ready_list[i].id == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void ready_drop(int pos);
        for (int k = pos; k + 1 < ready_used; k++) begin
            ready_list[k] = ready_list[k+1];
        end
        ready_used--;
    endfunction

    // Carries out one request on the mirror and returns the result it should produce.
    function automatic sched_result_t apply_request(kind_t kind, logic [ID_W-1:0] id,
                                                    logic [PRIO_W-1:0] prio,
                                                    logic [STEP_W-1:0] step);
        sched_result_t res;
        entry_t        e;
        int            pos;
        res.status = ST_OK;
        e.id   = id;
        e.prio = prio;
        e.step = step;
        case (kind)
            K_INSERT: begin
                if (!ready_push_sorted(e)) begin
                    res.status = ST_READY_FULL;
                end
            end
            K_REMOVE: begin
                pos = ready_find(id);
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    ready_drop(pos);
                end
            end
            K_MOVE: begin
                // A missing id is reported ahead of a full stack.
                pos = ready_find(id);
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else if (stack_used >= STACK_DEPTH_DEF) begin
                    res.status = ST_STACK_FULL;
                end else begin
                    wait_stack[stack_used] = ready_list[pos];
                    stack_used++;
                    ready_drop(pos);
                end
            end
            default: begin
                // Waking into a full ready list leaves the entry on the stack.
                if (stack_used == 0) begin
                    res.status = ST_STACK_EMPTY;
                end else if (!ready_push_sorted(wait_stack[stack_used-1])) begin
                    res.status = ST_READY_FULL;
                end else begin
                    stack_used--;
                end
            end
        endcase
        res.head_valid    = (ready_used > 0);
        res.head_id       = (ready_used > 0) ? ready_list[0].id : '0;
        res.ready_count   = COUNT_W'(ready_used);
        res.waiting_count = COUNT_W'(stack_used);
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------------------

    // Issues one request transaction. The expected result is queued before the request is
    // offered, which is safe because a request once offered is never withdrawn. Inputs
    // change only at the falling edge; the handshake is judged at the rising edge.
    task automatic send_request(kind_t kind, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                                logic [STEP_W-1:0] step);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
        owed_results.push_back(apply_request(kind, id, prio, step));
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tdata  = {step, prio, id};
        s_tuser  = kind;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Priorities and steps are often drawn from a tiny range so that equal keys, and
    // hence the first come first served rule, turn up regularly.
    function automatic logic [PRIO_W-1:0] rand_prio();
        return ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                           : PRIO_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [STEP_W-1:0] rand_step();
        return ($urandom_range(0, 1) == 0) ? STEP_W'($urandom_range(0, 3))
                                           : STEP_W'($urandom_range(0, 65535));
    endfunction

    // An id that is in the ready list now, or a random one when the list is empty.
    function automatic logic [ID_W-1:0] pick_ready_id();
        if (ready_used == 0) begin
            return ID_W'($urandom_range(0, 65535));
        end
        return ready_list[$urandom_range(0, ready_used - 1)].id;
    endfunction

    // One random request whose kind leans towards filling or draining the lists.
    // About one in ten is pure noise with every field drawn at random.
    task automatic send_random_request(mix_t mix);
        int              roll;
        kind_t           kind;
        logic [ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  kind = (roll < 60) ? K_INSERT : (roll < 80) ? K_MOVE :
                              (roll < 88) ? K_REMOVE : K_WAKE;
            MIX_DRAIN: kind = (roll < 15) ? K_INSERT : (roll < 50) ? K_REMOVE :
                              (roll < 65) ? K_MOVE : K_WAKE;
            default:   kind = kind_t'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            send_request(kind_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 65535)),
                         PRIO_W'($urandom_range(0, 255)), STEP_W'($urandom_range(0, 65535)));
        end else begin
            if (kind == K_INSERT) begin
                // Some inserts reuse a live id so that duplicates exist.
                id = ($urandom_range(0, 9) < 3) ? pick_ready_id()
                                                : ID_W'($urandom_range(0, 65535));
            end else begin
                id = ($urandom_range(0, 9) < 7) ? pick_ready_id()
                                                : ID_W'($urandom_range(0, 65535));
            end
            send_request(kind, id, rand_prio(), rand_step());
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------------------

    task automatic note_fault(string what, longint unsigned want, longint unsigned got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // Compares the result transaction just taken with the oldest one owed.
    task automatic check_result();
        sched_result_t want;
        if (owed_results.size() == 0) begin
            note_fault("result with nothing outstanding", 0, {m_tuser, m_tdata});
        end else begin
            want = owed_results.pop_front();
            if (m_tuser !== want.status)
                note_fault("status", want.status, m_tuser);
            if (m_tdata[0] !== want.head_valid)
                note_fault("head_valid", want.head_valid, m_tdata[0]);
            if (m_tdata[16:1] !== want.head_id)
                note_fault("head_id", want.head_id, m_tdata[16:1]);
            if (m_tdata[21:17] !== want.ready_count)
                note_fault("ready_count", want.ready_count, m_tdata[21:17]);
            if (m_tdata[26:22] !== want.waiting_count)
                note_fault("waiting_count", want.waiting_count, m_tdata[26:22]);
            if (m_tdata[31:27] !== 5'b0)
                note_fault("tdata padding", 0, m_tdata[31:27]);
        end
    endtask

    // Receiver: stalls for a random number of cycles before each result, or for a long
    // stretch when a test asks for one, then keeps tready high until a transaction lands.
    // tready is only ever raised again, never dropped and raised, within one falling edge.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = receiver_gaps_on ? $urandom_range(0, 5) : 0;
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            repeat (gap) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) begin
                @(posedge aclk);
            end
            check_result();
        end
    end

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Requests that find nothing to work on straight after reset.
    task automatic test_empty_store();
        send_request(K_WAKE, 16'h0000, 8'h00, 16'h0000);
        send_request(K_REMOVE, 16'hffff, 8'hff, 16'hffff);
        send_request(K_MOVE, 16'h0000, 8'h5a, 16'ha5a5);
    endtask

    // Field extremes, every kind, equal keys kept in arrival order and a duplicate id
    // where the first match in list order must be the one taken.
    task automatic test_ordering_rules();
        send_request(K_INSERT, 16'h0000, 8'h00, 16'h0000);
        send_request(K_INSERT, 16'hffff, 8'hff, 16'hffff);
        send_request(K_INSERT, 16'h0001, 8'hff, 16'h0000);
        send_request(K_INSERT, 16'h000a, 8'h08, 16'h0005);
        send_request(K_INSERT, 16'h000b, 8'h08, 16'h0005);
        send_request(K_INSERT, 16'h000c, 8'h08, 16'h0005);
        send_request(K_INSERT, 16'h000d, 8'h08, 16'h0004);
        send_request(K_INSERT, 16'h000a, 8'hc8, 16'h0009);
        send_request(K_REMOVE, 16'h000a, 8'hff, 16'hffff);
        send_request(K_REMOVE, 16'h0001, 8'h00, 16'h0000);
        send_request(K_MOVE, 16'h000b, 8'h77, 16'h1234);
        send_request(K_MOVE, 16'h000c, 8'h00, 16'h0000);
        send_request(K_WAKE, 16'hbeef, 8'hff, 16'hffff);
        send_request(K_REMOVE, 16'h1234, 8'h00, 16'h0000);
        send_request(K_MOVE, 16'h4321, 8'h00, 16'h0000);
        send_request(K_REMOVE, 16'hffff, 8'h00, 16'h0000);
        send_request(K_WAKE, 16'h0000, 8'h00, 16'h0000);
        send_request(K_WAKE, 16'h0000, 8'h00, 16'h0000);
    endtask

    // Drives both lists to capacity: insert into a full ready list, move onto a full
    // stack, wake into a full ready list, then empties everything again.
    task automatic test_capacity_limits();
        while (ready_used < READY_DEPTH_DEF) begin
            send_request(K_INSERT, ID_W'($urandom_range(0, 65535)), rand_prio(), rand_step());
        end
        send_request(K_INSERT, ID_W'($urandom_range(0, 65535)), rand_prio(), rand_step());
        while (stack_used < STACK_DEPTH_DEF) begin
            if (ready_used == 0) begin
                send_request(K_INSERT, ID_W'($urandom_range(0, 65535)), rand_prio(),
                             rand_step());
            end
            send_request(K_MOVE, pick_ready_id(), rand_prio(), rand_step());
        end
        while (ready_used < READY_DEPTH_DEF) begin
            send_request(K_INSERT, ID_W'($urandom_range(0, 65535)), rand_prio(), rand_step());
        end
        send_request(K_MOVE, pick_ready_id(), rand_prio(), rand_step());
        send_request(K_WAKE, ID_W'($urandom_range(0, 65535)), rand_prio(), rand_step());
        repeat (3) begin
            send_request(K_REMOVE, pick_ready_id(), rand_prio(), rand_step());
            send_request(K_WAKE, ID_W'($urandom_range(0, 65535)), rand_prio(), rand_step());
        end
        while (ready_used > 0 || stack_used > 0) begin
            if (ready_used > 0) begin
                send_request(K_REMOVE, pick_ready_id(), rand_prio(), rand_step());
            end else begin
                send_request(K_WAKE, ID_W'($urandom_range(0, 65535)), rand_prio(),
                             rand_step());
            end
        end
    endtask

    // Long random run in episodes that lean towards filling, draining or neither. Gaps
    // on either side are switched off now and then so that back-to-back transactions
    // happen, and every few episodes the sender waits for the block to drain.
    task automatic test_random_traffic();
        int   issued;
        int   episode;
        int   span;
        mix_t mix;
        issued  = 0;
        episode = 0;
        while (issued < RANDOM_REQUESTS) begin
            mix              = mix_t'($urandom_range(0, 2));
            span             = $urandom_range(10, 40);
            sender_gaps_on   = ($urandom_range(0, 3) != 0);
            receiver_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (span) begin
                send_random_request(mix);
                issued++;
            end
            episode++;
            if (episode % 8 == 0) begin
                // The last request has been taken, so tvalid comes down before waiting.
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait (owed_results.size() == 0);
            end
        end
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // output register and the apply stage fill and tready on the request side drops.
    // Afterwards the sender pauses until every result is back before carrying on.
    task automatic test_output_stall();
        rx_hold_cycles = 80;
        sender_gaps_on = 1'b0;
        repeat (12) begin
            send_random_request(MIX_FILL);
        end
        sender_gaps_on = 1'b1;
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (owed_results.size() == 0);
        repeat (8) begin
            send_random_request(MIX_EVEN);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        ready_used       = 0;
        stack_used       = 0;
        fault_count      = 0;
        cycle_count      = 0;
        rx_hold_cycles   = 0;
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_store();
        test_ordering_rules();
        test_capacity_limits();
        test_random_traffic();
        test_output_stall();

        @(negedge aclk);
        s_tvalid = 1'b0;

        // Let the last results arrive, then watch a little longer for stray ones.
        wait (owed_results.size() == 0);
        repeat (10) @(posedge aclk);
        if (fault_count == 0) begin
            $display("ready_queue_with_wait_stack_tb: clean");
        end else begin
            $display("ready_queue_with_wait_stack_tb: errors");
        end
        $finish;
    end

endmodule
